// ===== hw/rtl/cca_pkg.sv =====
// Package with the transfer types and constants of the color class assigner.
package cca_pkg;

  localparam int MAX_CLASSES_DEF = 255;
  localparam int COLOR_W         = 24;
  localparam int CLASS_W         = 8;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               first_of_scene;
  } in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_number;
    logic               is_new_color;
    logic               overflow_seen;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
    logic               hit;
    logic               is_new;
    logic [CLASS_W-1:0] cls;
  } tok_t;

endpackage

// ===== hw/rtl/cca_cell.sv =====
// One table cell: holds a stored color and passes the lookup token to its neighbor.
module cca_cell
  import cca_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tok_t             tok_in,
  input  logic [CNT_W-1:0] count,
  output tok_t             tok_out
);

  logic [COLOR_W-1:0] color_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               active;
  logic               match;
  logic               append;

  assign active = CNT_W'(IDX) < count;
  assign match  = tok_in.valid && active && (color_r == tok_in.color);
  assign append = tok_in.valid && !tok_in.hit && (CNT_W'(IDX) == count);

  always_comb begin
    tok_nxt = tok_in;
    if (match || append) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.cls = CLASS_W'(IDX + 1);
    end
    if (append) begin
      tok_nxt.is_new = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.color  <= tok_nxt.color;
    tok_r.hit    <= tok_nxt.hit;
    tok_r.is_new <= tok_nxt.is_new;
    tok_r.cls    <= tok_nxt.cls;
    if (append) begin
      color_r <= tok_in.color;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hw/rtl/color_class_assigner_core.sv =====
// Top level of the color class assigner: cell chain, entry count and overflow flag.
//
//   channel  ports                        transfer
//   input    start, busy, in_data         at a clock edge with start high and busy low
//   output   out_strobe, out_data         in every cycle that out_strobe is high
//
// A color walks the chain of MAX_CLASSES cells one cell per cycle, and busy stays high
// until its result appears: a new color can be taken in the cycle of that result, so
// only one color is in the chain at a time. Reset is synchronous and clears the entry
// count, the overflow flag and all control state; the stored colors are not cleared
// and need no sweep. The receiver cannot stall, so a result is shown once.
module color_class_assigner_core
  import cca_pkg::*;
#(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data
);

  localparam int CNT_W = $clog2(MAX_CLASSES + 1);

  tok_t             tok [0:MAX_CLASSES];
  tok_t             tok0_r;
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             busy_r;
  logic             out_strobe_r;
  out_t             out_data_r;
  logic             accept;
  tok_t             last;
  logic [MAX_CLASSES:0] tok_valids;

  assign accept = start && !busy_r;
  assign tok[0] = tok0_r;
  assign last   = tok[MAX_CLASSES];

  generate
    for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_cell
      cca_cell #(
        .IDX   (g),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok[g]),
        .count   (count_r),
        .tok_out (tok[g+1])
      );
    end
    for (genvar v = 0; v <= MAX_CLASSES; v++) begin : g_valid
      assign tok_valids[v] = tok[v].valid;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.valid <= 1'b0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      tok0_r.valid <= accept;
      out_strobe_r <= last.valid;
      if (accept) begin
        busy_r <= 1'b1;
        if (in_data.first_of_scene) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
      end
      if (last.valid) begin
        busy_r <= 1'b0;
        if (last.is_new) begin
          count_r <= count_r + 1'b1;
        end
        if (!last.hit) begin
          ovf_r <= 1'b1;
        end
      end
    end
    tok0_r.color  <= in_data.pixel_color;
    tok0_r.hit    <= 1'b0;
    tok0_r.is_new <= 1'b0;
    tok0_r.cls    <= '0;
    out_data_r.class_number  <= last.hit ? last.cls : '0;
    out_data_r.is_new_color  <= last.is_new;
    out_data_r.overflow_seen <= ovf_r || !last.hit;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valids) <= 1)
    else $error("more than one lookup in the cell chain");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CLASSES))
    else $error("entry count beyond table size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> count_r == CNT_W'(MAX_CLASSES))
    else $error("overflow set while table not full");

  a_new_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.is_new_color |-> out_data.class_number == CLASS_W'(count_r))
    else $error("new color class differs from entry count");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after transfer");

endmodule
